@@ hdl/b64sig_pkg.sv @@
package b64sig_pkg;

	// byte count fits this width for header sizes up to 127 bytes
	localparam int unsigned DCNT_W = 7;
	localparam int unsigned STORE_DEPTH = 8;
	localparam int unsigned NUM_TYPES = 3;

	localparam logic [7:0] CH_PAD = 8'h3D;

	typedef enum logic [1:0] {
		FT_NONE = 2'd0,
		FT_PNG  = 2'd1,
		FT_JPEG = 2'd2,
		FT_PDF  = 2'd3
	} ft_t;

	// one finished text, handed from front to back
	typedef struct packed {
		logic [NUM_TYPES-1:0]            match;
		logic                            fail;
		logic                            impure;
		logic [DCNT_W-1:0]               total;
		logic [STORE_DEPTH-1:0][7:0]     store;
	} snap_t;

	// sextet value with bad flag in bit 6
	function automatic logic [6:0] sextet(input logic [7:0] c);
		logic [6:0] r;
		r = 7'h40;
		if (c >= 8'h41 && c <= 8'h5A) r = {1'b0, 6'(c - 8'h41)};
		else if (c >= 8'h61 && c <= 8'h7A) r = {1'b0, 6'(c - 8'h61 + 8'd26)};
		else if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 6'(c - 8'h30 + 8'd52)};
		else if (c == 8'h2B) r = 7'd62;
		else if (c == 8'h2F) r = 7'd63;
		return r;
	endfunction

	function automatic logic [2:0] pfx_len(input logic [1:0] t);
		logic [2:0] r;
		case (t)
			2'd0: r = 3'd7;
			2'd1: r = 3'd4;
			2'd2: r = 3'd5;
			default: r = 3'd7;
		endcase
		return r;
	endfunction

	// base64 prefixes: "iVBORw0", "/9j/", "JVBER"
	function automatic logic [7:0] pfx_char(input logic [1:0] t, input logic [2:0] i);
		logic [7:0] r;
		r = 8'h00;
		case (t)
			2'd0: begin
				case (i)
					3'd0: r = 8'h69;
					3'd1: r = 8'h56;
					3'd2: r = 8'h42;
					3'd3: r = 8'h4F;
					3'd4: r = 8'h52;
					3'd5: r = 8'h77;
					3'd6: r = 8'h30;
					default: r = 8'h00;
				endcase
			end
			2'd1: begin
				case (i)
					3'd0: r = 8'h2F;
					3'd1: r = 8'h39;
					3'd2: r = 8'h6A;
					3'd3: r = 8'h2F;
					default: r = 8'h00;
				endcase
			end
			2'd2: begin
				case (i)
					3'd0: r = 8'h4A;
					3'd1: r = 8'h56;
					3'd2: r = 8'h42;
					3'd3: r = 8'h45;
					3'd4: r = 8'h52;
					default: r = 8'h00;
				endcase
			end
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] magic_len(input logic [1:0] t);
		logic [3:0] r;
		case (t)
			2'd0: r = 4'd8;
			2'd1: r = 4'd3;
			2'd2: r = 4'd5;
			default: r = 4'd8;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] magic_byte(input logic [1:0] t, input logic [2:0] i);
		logic [7:0] r;
		r = 8'h00;
		case (t)
			2'd0: begin
				case (i)
					3'd0: r = 8'h89;
					3'd1: r = 8'h50;
					3'd2: r = 8'h4E;
					3'd3: r = 8'h47;
					3'd4: r = 8'h0D;
					3'd5: r = 8'h0A;
					3'd6: r = 8'h1A;
					3'd7: r = 8'h0A;
					default: r = 8'h00;
				endcase
			end
			2'd1: begin
				case (i)
					3'd0: r = 8'hFF;
					3'd1: r = 8'hD8;
					3'd2: r = 8'hFF;
					default: r = 8'h00;
				endcase
			end
			2'd2: begin
				case (i)
					3'd0: r = 8'h25;
					3'd1: r = 8'h50;
					3'd2: r = 8'h44;
					3'd3: r = 8'h46;
					3'd4: r = 8'h2D;
					default: r = 8'h00;
				endcase
			end
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic jpeg_marker_ok(input logic [7:0] m);
		return (m >= 8'hE0 && m <= 8'hEF) || (m >= 8'hC0 && m <= 8'hCF) ||
		       m == 8'hDB || m == 8'hDA || m == 8'hDD || m == 8'hFE;
	endfunction

endpackage

@@ hdl/b64sig_front.sv @@
module b64sig_front
	import b64sig_pkg::*;
#(
	parameter int unsigned HEADER_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_in,
	input  logic        last_char,
	input  logic        q_full,
	output logic        push,
	output snap_t       push_data
);

	localparam int unsigned WINDOW = ((HEADER_BYTES + 2) / 3) * 4;
	localparam int unsigned PW = $clog2(WINDOW + 1);
	localparam int unsigned CW = $clog2(HEADER_BYTES + 1);

	logic [PW-1:0] pos_q, pos_n;
	logic [NUM_TYPES-1:0] alive_q, alive_n;
	logic [7:0] p0_q, p1_q, p2_q;
	logic [CW-1:0] total_q, total_n;
	logic [7:0] store_q [STORE_DEPTH];
	logic [7:0] store_n [STORE_DEPTH];
	logic fail_q, fail_n;
	logic [1:0] pad_q, pad_n;
	logic impure_q, impure_n;

	logic accept, in_win, do_group;
	logic [6:0] sa, sb, sc, sd;
	logic [2:0] wr_en;
	logic [CW-1:0] wr_idx [3];
	logic [7:0] wr_byte [3];
	logic [CW-1:0] n1, n2;
	logic [6:0] sx;

	assign in_stall = q_full;
	assign accept = in_valid && !q_full;
	assign push = accept && last_char;

	// track prefixes and the character window
	always_comb begin
		alive_n = alive_q;
		for (int t = 0; t < NUM_TYPES; t++) begin
			if (pos_q < PW'(pfx_len(2'(t))) && char_in != pfx_char(2'(t), pos_q[2:0]))
				alive_n[t] = 1'b0;
		end
		in_win = pos_q < PW'(WINDOW);
		pos_n = in_win ? pos_q + PW'(1) : pos_q;
		do_group = in_win && (pos_q[1:0] == 2'd3);
	end

	// decode a complete group into up to three bytes
	always_comb begin
		sa = sextet(p0_q);
		sb = sextet(p1_q);
		sc = sextet(p2_q);
		sd = sextet(char_in);
		n1 = total_q + CW'(1);
		n2 = total_q + CW'(2);
		wr_en = 3'b000;
		wr_idx[0] = total_q;
		wr_idx[1] = n1;
		wr_idx[2] = n2;
		wr_byte[0] = {sa[5:0], sb[5:4]};
		wr_byte[1] = {sb[3:0], sc[5:2]};
		wr_byte[2] = {sc[1:0], sd[5:0]};
		fail_n = fail_q;
		total_n = total_q;
		if (do_group && !fail_q && total_q < CW'(HEADER_BYTES)) begin
			if (sa[6] || sb[6]) begin
				fail_n = 1'b1;
			end else begin
				wr_en[0] = 1'b1;
				total_n = n1;
				if (n1 < CW'(HEADER_BYTES) && !sc[6]) begin
					wr_en[1] = 1'b1;
					total_n = n2;
					if (n2 < CW'(HEADER_BYTES) && !sd[6]) begin
						wr_en[2] = 1'b1;
						total_n = n2 + CW'(1);
					end
				end
			end
		end
		for (int e = 0; e < STORE_DEPTH; e++) begin
			store_n[e] = store_q[e];
			for (int k = 0; k < 3; k++) begin
				if (wr_en[k] && wr_idx[k] == CW'(e)) store_n[e] = wr_byte[k];
			end
		end
	end

	// check purity and trailing padding
	always_comb begin
		sx = sextet(char_in);
		pad_n = pad_q;
		impure_n = impure_q;
		if (char_in == CH_PAD) begin
			if (pad_q >= 2'd2) impure_n = 1'b1;
			else pad_n = pad_q + 2'd1;
		end else if (pad_q != 2'd0 || sx[6]) begin
			impure_n = 1'b1;
		end
	end

	// assemble the finished text for judging
	always_comb begin
		for (int t = 0; t < NUM_TYPES; t++)
			push_data.match[t] = alive_n[t] && pos_n >= PW'(pfx_len(2'(t)));
		push_data.fail = fail_n;
		push_data.impure = impure_n;
		push_data.total = DCNT_W'(total_n);
		for (int e = 0; e < STORE_DEPTH; e++)
			push_data.store[e] = store_n[e];
	end

	// advance text state, clear after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			alive_q <= '1;
			total_q <= '0;
			fail_q <= 1'b0;
			pad_q <= 2'd0;
			impure_q <= 1'b0;
		end else if (accept) begin
			if (last_char) begin
				pos_q <= '0;
				alive_q <= '1;
				total_q <= '0;
				fail_q <= 1'b0;
				pad_q <= 2'd0;
				impure_q <= 1'b0;
			end else begin
				pos_q <= pos_n;
				alive_q <= alive_n;
				total_q <= total_n;
				fail_q <= fail_n;
				pad_q <= pad_n;
				impure_q <= impure_n;
			end
		end
	end

	// hold group characters and decoded header bytes
	always_ff @(posedge clk) begin
		if (accept) begin
			if (in_win && pos_q[1:0] == 2'd0) p0_q <= char_in;
			if (in_win && pos_q[1:0] == 2'd1) p1_q <= char_in;
			if (in_win && pos_q[1:0] == 2'd2) p2_q <= char_in;
			for (int e = 0; e < STORE_DEPTH; e++)
				store_q[e] <= store_n[e];
		end
	end

endmodule

@@ hdl/b64sig_queue.sv @@
module b64sig_queue
	import b64sig_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  snap_t push_data,
	output logic  full,
	output logic  pop_valid,
	input  logic  pop,
	output snap_t pop_data
);

	snap_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign pop_valid = cnt_q != 2'd0;
	assign pop_data = mem_q[rp_q];

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	// hold queued requests
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

endmodule

@@ hdl/b64sig_back.sv @@
module b64sig_back
	import b64sig_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [6:0]  min_len,
	input  logic        q_valid,
	input  snap_t       q_data,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  det_type
);

	logic ov_q;
	ft_t ft_q, ft_n;
	logic load, found, ok;

	// judge the first matching prefix
	always_comb begin
		ft_n = FT_NONE;
		found = 1'b0;
		ok = 1'b0;
		for (int t = 0; t < NUM_TYPES; t++) begin
			if (!found && q_data.match[t]) begin
				found = 1'b1;
				ok = !q_data.fail && q_data.total >= min_len &&
				     q_data.total >= DCNT_W'(magic_len(2'(t))) && !q_data.impure;
				for (int i = 0; i < STORE_DEPTH; i++) begin
					if (4'(i) < magic_len(2'(t)) &&
					    q_data.store[i] != magic_byte(2'(t), 3'(i)))
						ok = 1'b0;
				end
				if (t == 1 && !(q_data.total >= DCNT_W'(4) &&
				                jpeg_marker_ok(q_data.store[3])))
					ok = 1'b0;
				if (ok) ft_n = ft_t'(2'(t + 1));
			end
		end
	end

	assign load = !ov_q || !out_stall;
	assign pop = q_valid && load;
	assign out_valid = ov_q;
	assign det_type = ft_q;

	// hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (load) ov_q <= q_valid;
	end

	always_ff @(posedge clk) begin
		if (pop) ft_q <= ft_n;
	end

endmodule

@@ hdl/base64_file_signature_detector.sv @@
// Accepts one character per cycle; the front stalls only when the two-entry queue is full.
// A last character's request enters the queue at its accepting edge, and the back moves
// its type into the output register once that register is empty or not stalled.
// Throughput: one character per cycle while the queue is not full, one result per text.
// Reset: asynchronous, active low; clears text state, queue and output valid,
// and sets the minimum decoded length to 16.
module base64_file_signature_detector
	import b64sig_pkg::*;
#(
	parameter int unsigned HEADER_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_in,
	input  logic        last_char,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  det_type
);

	logic [6:0] min_len_q;
	logic push, q_full, q_valid, pop;
	snap_t push_data, pop_data;

	// hold the minimum decoded length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) min_len_q <= 7'd16;
		else if (cfg_we) min_len_q <= cfg_wdata;
	end

	b64sig_front #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_in   (char_in),
		.last_char (last_char),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	b64sig_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop       (pop),
		.pop_data  (pop_data)
	);

	b64sig_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.min_len   (min_len_q),
		.q_valid   (q_valid),
		.q_data    (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.det_type  (det_type)
	);

endmodule
